### rtl/bhs_pkg.sv
// bhs_pkg: shared constants and types for the bilinear heightmap sampler.
// No dependencies; imported by every module in rtl/.
package bhs_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int FRAC_BITS  = 8;

   localparam int PIX_W   = 16;
   localparam int ADDR_W  = 16;
   localparam int COORD_W = 17;
   localparam int SIZE_W  = 9;
   localparam int OUT_W   = 24;
   localparam int POS_W   = $clog2(MAX_WIDTH);
   localparam int WT_W    = FRAC_BITS + 1;
   localparam int ROW_W   = PIX_W + FRAC_BITS;
   localparam int ACC_W   = ROW_W + FRAC_BITS;

   localparam logic [WT_W-1:0] ONE_FIX = WT_W'(1) << FRAC_BITS;

   localparam logic       FUNC_WRITE  = 1'b0;
   localparam logic       FUNC_SAMPLE = 1'b1;

   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;

   // One classified word as it travels from the front end to the back end.
   typedef struct packed {
      logic                 func;
      logic [ADDR_W-1:0]    addr;
      logic [PIX_W-1:0]     value;
      logic [POS_W-1:0]     x0;
      logic [POS_W-1:0]     x1;
      logic [ADDR_W-1:0]    row0;
      logic [ADDR_W-1:0]    row1;
      logic [FRAC_BITS-1:0] tx;
      logic [FRAC_BITS-1:0] ty;
   } entry_type;

endpackage

### rtl/bhs_front.sv
// bhs_front: classifies an incoming word, clamps sample coordinates and
// precomputes neighbor columns and row base addresses. Uses bhs_pkg.
module bhs_front import bhs_pkg::*; (
   input  logic [SIZE_W-1:0]  map_width,
   input  logic [SIZE_W-1:0]  map_height,
   input  logic               req_func,
   input  logic [ADDR_W-1:0]  req_pixel_index,
   input  logic [PIX_W-1:0]   req_pixel_value,
   input  logic [COORD_W-1:0] req_sample_x,
   input  logic [COORD_W-1:0] req_sample_y,
   output entry_type          entry
);

   logic [SIZE_W-1:0]          w_eff, h_eff;
   logic [POS_W-1:0]           w_m1, h_m1;
   logic [COORD_W-2:0]         lim_x, lim_y, fx, fy;
   logic [POS_W-1:0]           x0, y0, x1, y1;
   logic [POS_W+SIZE_W-1:0]    prod0, prod1;

   always_comb begin
      // zero is taken as one, oversize as the maximum
      if (map_width == '0) begin
         w_eff = SIZE_W'(1);
      end else if (map_width > SIZE_W'(MAX_WIDTH)) begin
         w_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         w_eff = map_width;
      end
      if (map_height == '0) begin
         h_eff = SIZE_W'(1);
      end else if (map_height > SIZE_W'(MAX_HEIGHT)) begin
         h_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_eff = map_height;
      end
   end

   assign w_m1  = POS_W'(w_eff - SIZE_W'(1));
   assign h_m1  = POS_W'(h_eff - SIZE_W'(1));
   assign lim_x = {w_m1, {FRAC_BITS{1'b0}}};
   assign lim_y = {h_m1, {FRAC_BITS{1'b0}}};

   always_comb begin
      if (req_sample_x[COORD_W-1]) begin
         fx = '0;
      end else if (req_sample_x[COORD_W-2:0] > lim_x) begin
         fx = lim_x;
      end else begin
         fx = req_sample_x[COORD_W-2:0];
      end
      if (req_sample_y[COORD_W-1]) begin
         fy = '0;
      end else if (req_sample_y[COORD_W-2:0] > lim_y) begin
         fy = lim_y;
      end else begin
         fy = req_sample_y[COORD_W-2:0];
      end
   end

   assign x0 = fx[COORD_W-2:FRAC_BITS];
   assign y0 = fy[COORD_W-2:FRAC_BITS];
   assign x1 = (({1'b0, x0} + SIZE_W'(1)) < w_eff) ? x0 + POS_W'(1) : w_m1;
   assign y1 = (({1'b0, y0} + SIZE_W'(1)) < h_eff) ? y0 + POS_W'(1) : h_m1;

   assign prod0 = {{SIZE_W{1'b0}}, y0} * {{POS_W{1'b0}}, w_eff};
   assign prod1 = {{SIZE_W{1'b0}}, y1} * {{POS_W{1'b0}}, w_eff};

   always_comb begin
      entry.func  = req_func;
      entry.addr  = req_pixel_index;
      entry.value = req_pixel_value;
      entry.x0    = x0;
      entry.x1    = x1;
      entry.row0  = prod0[ADDR_W-1:0];
      entry.row1  = prod1[ADDR_W-1:0];
      entry.tx    = fx[FRAC_BITS-1:0];
      entry.ty    = fy[FRAC_BITS-1:0];
   end

endmodule

### rtl/bhs_queue.sv
// bhs_queue: two-entry FIFO of classified words between front and back end.
// Uses bhs_pkg for entry_type.
module bhs_queue import bhs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type pop_data,
   output logic      full,
   output logic      empty
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);

endmodule

### rtl/bhs_back.sv
// bhs_back: pixel memory, neighbor read sequencer and shared multiply-accumulate
// for the two row lerps and the column lerp. Uses bhs_pkg.
module bhs_back import bhs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  entry_type        q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   output logic [OUT_W-1:0] rsp_height_out
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD00 = 3'd1;
   localparam logic [2:0] ST_RD10 = 3'd2;
   localparam logic [2:0] ST_RD01 = 3'd3;
   localparam logic [2:0] ST_RD11 = 3'd4;
   localparam logic [2:0] ST_LX1  = 3'd5;
   localparam logic [2:0] ST_LY0  = 3'd6;
   localparam logic [2:0] ST_LY1  = 3'd7;

   localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;

   logic [PIX_W-1:0]   mem [MEM_DEPTH];
   logic [PIX_W-1:0]   rdata_ff;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;

   logic [2:0]         state_ff, state_in;
   entry_type          work_ff, work_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ROW_W-1:0]   r0_ff, r0_in, r1_ff, r1_in;
   logic               valid_ff, valid_in;
   logic [OUT_W-1:0]   height_ff, height_in;

   logic [ROW_W-1:0]   mul_a;
   logic [WT_W-1:0]    mul_b;
   logic               use_acc;
   logic [ROW_W+WT_W-1:0] prod;
   logic [ACC_W-1:0]   sum;

   assign mem_we = (state_ff == ST_IDLE) && !q_empty && (q_data.func == FUNC_WRITE);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: mem_addr = q_data.addr;
         ST_RD00: mem_addr = work_ff.row0 + ADDR_W'(work_ff.x0);
         ST_RD10: mem_addr = work_ff.row0 + ADDR_W'(work_ff.x1);
         ST_RD01: mem_addr = work_ff.row1 + ADDR_W'(work_ff.x0);
         ST_RD11: mem_addr = work_ff.row1 + ADDR_W'(work_ff.x1);
         default: mem_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= q_data.value;
      end
      rdata_ff <= mem[mem_addr];
   end

   // one product per cycle; the second product of each pair adds to the partial sum
   always_comb begin
      mul_a   = ROW_W'(rdata_ff);
      mul_b   = ONE_FIX - WT_W'(work_ff.tx);
      use_acc = 1'b0;
      case (state_ff)
         ST_RD01, ST_LX1: begin
            mul_b   = WT_W'(work_ff.tx);
            use_acc = 1'b1;
         end
         ST_LY0: begin
            mul_a = r0_ff;
            mul_b = ONE_FIX - WT_W'(work_ff.ty);
         end
         ST_LY1: begin
            mul_a   = r1_ff;
            mul_b   = WT_W'(work_ff.ty);
            use_acc = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign prod = {{WT_W{1'b0}}, mul_a} * {{ROW_W{1'b0}}, mul_b};
   assign sum  = (use_acc ? acc_ff : '0) + prod[ACC_W-1:0];

   always_comb begin
      state_in  = state_ff;
      work_in   = work_ff;
      acc_in    = acc_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      valid_in  = 1'b0;
      height_in = height_ff;
      q_pop     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_data.func == FUNC_SAMPLE) begin
                  work_in  = q_data;
                  state_in = ST_RD00;
               end
            end
         end
         ST_RD00: state_in = ST_RD10;
         ST_RD10: begin
            acc_in   = sum;
            state_in = ST_RD01;
         end
         ST_RD01: begin
            r0_in    = sum[ROW_W-1:0];
            state_in = ST_RD11;
         end
         ST_RD11: begin
            acc_in   = sum;
            state_in = ST_LX1;
         end
         ST_LX1: begin
            r1_in    = sum[ROW_W-1:0];
            state_in = ST_LY0;
         end
         ST_LY0: begin
            acc_in   = sum;
            state_in = ST_LY1;
         end
         ST_LY1: begin
            height_in = sum[FRAC_BITS +: OUT_W];
            valid_in  = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      acc_ff    <= acc_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      height_ff <= height_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_height_out = height_ff;

endmodule

### rtl/bilinear_heightmap_sample.sv
// bilinear_heightmap_sample: 256x256 16-bit heightmap with bilinear sampling.
// A write word leaves the queue and updates memory when the back end is idle;
// a sample steps the back end through four reads from the single-port pixel
// memory plus multiply-accumulate steps, then strobes its result. Words queue
// while a sample runs; busy is raised while the queue is full.
// Synchronous active-high reset clears control and sets both size registers to 256.
module bilinear_heightmap_sample import bhs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [ADDR_W-1:0]  req_pixel_index,
   input  logic [PIX_W-1:0]   req_pixel_value,
   input  logic [COORD_W-1:0] req_sample_x,
   input  logic [COORD_W-1:0] req_sample_y,
   output logic               rsp_valid,
   output logic [OUT_W-1:0]   rsp_height_out,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [SIZE_W-1:0]  csr_write_data
);

   logic [SIZE_W-1:0] map_width_ff, map_width_in;
   logic [SIZE_W-1:0] map_height_ff, map_height_in;
   entry_type         front_entry, q_data;
   logic              q_push, q_pop, q_full, q_empty;

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_write_data;
            CSR_MAP_HEIGHT: map_height_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= SIZE_W'(MAX_WIDTH);
         map_height_ff <= SIZE_W'(MAX_HEIGHT);
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   bhs_front u_front (
      .map_width       (map_width_ff),
      .map_height      (map_height_ff),
      .req_func        (req_func),
      .req_pixel_index (req_pixel_index),
      .req_pixel_value (req_pixel_value),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .entry           (front_entry)
   );

   assign busy   = q_full;
   assign q_push = start && !q_full;

   bhs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_entry),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   bhs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_height_out (rsp_height_out)
   );

`ifndef NO_ASSERTIONS
   // a sample ends with a single strobe and the sequencer returns to idle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |=> !q_empty)
      else $error("queue lost words");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");
`endif

endmodule

### tb/bilinear_heightmap_sample_checker.sv
`timescale 1ns / 100ps
// bilinear_heightmap_sample_checker: scoreboard for the heightmap sampler.
// Mirrors pixel writes and size registers, predicts each sample's height and
// compares it with the rsp word stream. Depends on bhs_pkg.
module bilinear_heightmap_sample_checker import bhs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_func,
   input  logic [ADDR_W-1:0]  req_pixel_index,
   input  logic [PIX_W-1:0]   req_pixel_value,
   input  logic [COORD_W-1:0] req_sample_x,
   input  logic [COORD_W-1:0] req_sample_y,
   input  logic               rsp_valid,
   input  logic [OUT_W-1:0]   rsp_height_out,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [SIZE_W-1:0]  csr_write_data,
   output int                 fail_count,
   output int                 pending_results,
   output int                 results_checked
);

   logic [PIX_W-1:0]  height_copy [MAX_WIDTH*MAX_HEIGHT];
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;
   logic [OUT_W-1:0]  expected_heights [$];

   function automatic int unsigned usable_size(logic [SIZE_W-1:0] r, int unsigned limit);
      if (r == 0) return 1;
      if (r > limit) return limit;
      return r;
   endfunction

   // negative coordinates go to zero, anything past lim stops at lim
   function automatic int unsigned clamp_fix(logic [COORD_W-1:0] c, int unsigned lim);
      if (c[COORD_W-1]) return 0;
      return (c > lim) ? lim : c;
   endfunction

   // a + floor((b - a) * t / 2^FRAC_BITS), kept exact with unsigned terms
   function automatic longint unsigned lerp_floor(longint unsigned a, longint unsigned b,
                                                  int unsigned t);
      return (a * ((1 << FRAC_BITS) - t) + b * t) >> FRAC_BITS;
   endfunction

   function automatic logic [OUT_W-1:0] predict_height(logic [COORD_W-1:0] sx,
                                                       logic [COORD_W-1:0] sy);
      int unsigned     w, h, fx, fy, x0, x1, y0, y1, tx, ty;
      longint unsigned p00, p01, p10, p11, row0, row1;
      w  = usable_size(width_reg, MAX_WIDTH);
      h  = usable_size(height_reg, MAX_HEIGHT);
      fx = clamp_fix(sx, (w - 1) << FRAC_BITS);
      fy = clamp_fix(sy, (h - 1) << FRAC_BITS);
      x0 = fx >> FRAC_BITS;
      y0 = fy >> FRAC_BITS;
      tx = fx & ((1 << FRAC_BITS) - 1);
      ty = fy & ((1 << FRAC_BITS) - 1);
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      p00  = {height_copy[y0 * w + x0], {FRAC_BITS{1'b0}}};
      p01  = {height_copy[y0 * w + x1], {FRAC_BITS{1'b0}}};
      p10  = {height_copy[y1 * w + x0], {FRAC_BITS{1'b0}}};
      p11  = {height_copy[y1 * w + x1], {FRAC_BITS{1'b0}}};
      row0 = lerp_floor(p00, p01, tx);
      row1 = lerp_floor(p10, p11, tx);
      return OUT_W'(lerp_floor(row0, row1, ty));
   endfunction

   initial begin
      fail_count      = 0;
      pending_results = 0;
      results_checked = 0;
   end

   always @(posedge clock) begin : scoreboard
      logic [OUT_W-1:0] want_height;
      if (reset) begin
         width_reg  = SIZE_W'(MAX_WIDTH);
         height_reg = SIZE_W'(MAX_HEIGHT);
         expected_heights.delete();
      end else begin
         // retire before accepting: a result never belongs to a word taken this edge
         if (rsp_valid) begin
            if (expected_heights.size() == 0) begin
               $error("height_out: no sample outstanding, got %0d", rsp_height_out);
               fail_count++;
            end else begin
               want_height = expected_heights.pop_front();
               results_checked++;
               if (rsp_height_out !== want_height) begin
                  $error("height_out mismatch: expected %0d, actual %0d",
                         want_height, rsp_height_out);
                  fail_count++;
               end
            end
         end
         // a word taken on this edge still sees the old map size
         if (start && !busy) begin
            if (req_func == FUNC_WRITE) begin
               height_copy[req_pixel_index] = req_pixel_value;
            end else begin
               expected_heights.push_back(predict_height(req_sample_x, req_sample_y));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAP_WIDTH: begin
                  width_reg = csr_write_data;
               end
               CSR_MAP_HEIGHT: begin
                  height_reg = csr_write_data;
               end
               default: begin
               end
            endcase
         end
      end
      pending_results = expected_heights.size();
   end

endmodule

### tb/bilinear_heightmap_sample_tb.sv
`timescale 1ns / 100ps
// bilinear_heightmap_sample_tb: stimulus and verdict for the heightmap sampler.
// Drives pixel writes, samples and map sizes; bilinear_heightmap_sample_checker
// predicts and compares. Depends on bhs_pkg and the RTL.
module bilinear_heightmap_sample_tb;
   import bhs_pkg::*;

   localparam int NUM_SHAPES      = 10;
   localparam int WORDS_PER_SHAPE = 145;
   localparam int SETTLE_CYCLES   = 16;
   localparam int STALL_LIMIT     = 4000;

   // indexes with no register behind them
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_func;
   logic [ADDR_W-1:0]  req_pixel_index;
   logic [PIX_W-1:0]   req_pixel_value;
   logic [COORD_W-1:0] req_sample_x;
   logic [COORD_W-1:0] req_sample_y;
   logic               rsp_valid;
   logic [OUT_W-1:0]   rsp_height_out;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [SIZE_W-1:0]  csr_write_data;
   int                 fail_count;
   int                 pending_results;
   int                 results_checked;

   logic [SIZE_W-1:0] shape_w [NUM_SHAPES] =
      '{9'd256, 9'd1, 9'd0, 9'd511, 9'd1, 9'd256, 9'd3, 9'd2, 9'd17, 9'd40};
   logic [SIZE_W-1:0] shape_h [NUM_SHAPES] =
      '{9'd256, 9'd1, 9'd0, 9'd257, 9'd256, 9'd1, 9'd5, 9'd2, 9'd9, 9'd13};

   bit          px_written [MAX_WIDTH*MAX_HEIGHT];
   int unsigned map_w;
   int unsigned map_h;
   int          idle_pct;
   int          write_words;
   int          sample_words;

   bilinear_heightmap_sample DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_pixel_index  (req_pixel_index),
      .req_pixel_value  (req_pixel_value),
      .req_sample_x     (req_sample_x),
      .req_sample_y     (req_sample_y),
      .rsp_valid        (rsp_valid),
      .rsp_height_out   (rsp_height_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bilinear_heightmap_sample_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_pixel_index  (req_pixel_index),
      .req_pixel_value  (req_pixel_value),
      .req_sample_x     (req_sample_x),
      .req_sample_y     (req_sample_y),
      .rsp_valid        (rsp_valid),
      .rsp_height_out   (rsp_height_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .results_checked  (results_checked)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int unsigned usable_dim(logic [SIZE_W-1:0] r, int unsigned limit);
      if (r == 0) return 1;
      if (r > limit) return limit;
      return r;
   endfunction

   // integer pixel column/row a coordinate lands on after clamping
   function automatic int unsigned pixel_of(logic [COORD_W-1:0] c, int unsigned size);
      if (c[COORD_W-1]) return 0;
      if ((c >> FRAC_BITS) >= size - 1) return size - 1;
      return c >> FRAC_BITS;
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord(int unsigned size);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return COORD_W'($urandom_range((size - 1) << FRAC_BITS));
      if (roll < 76) return '0;
      if (roll < 82) return COORD_W'((size - 1) << FRAC_BITS);
      return COORD_W'($urandom);
   endfunction

   function automatic logic [PIX_W-1:0] pick_height();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return PIX_W'($urandom);
   endfunction

   task automatic send_word(input logic f, input logic [ADDR_W-1:0] idx,
                            input logic [PIX_W-1:0] val,
                            input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
      @(negedge clock);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start           = 1'b1;
      req_func        = f;
      req_pixel_index = idx;
      req_pixel_value = val;
      req_sample_x    = sx;
      req_sample_y    = sy;
      do @(posedge clock); while (busy);
      if (f == FUNC_WRITE) write_words++;
      else sample_words++;
   endtask

   task automatic put_pixel(input logic [ADDR_W-1:0] idx, input logic [PIX_W-1:0] val);
      px_written[idx] = 1'b1;
      send_word(FUNC_WRITE, idx, val, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   // fill any neighbour not yet written, then ask for the sample
   task automatic sample_at(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
      int unsigned cx0, cx1, cy0, cy1;
      int unsigned corner [4];
      cx0 = pixel_of(sx, map_w);
      cy0 = pixel_of(sy, map_h);
      cx1 = (cx0 + 1 < map_w) ? cx0 + 1 : map_w - 1;
      cy1 = (cy0 + 1 < map_h) ? cy0 + 1 : map_h - 1;
      corner = '{cy0 * map_w + cx0, cy0 * map_w + cx1, cy1 * map_w + cx0, cy1 * map_w + cx1};
      foreach (corner[i]) begin
         if (!px_written[corner[i]]) put_pixel(ADDR_W'(corner[i]), pick_height());
      end
      send_word(FUNC_SAMPLE, ADDR_W'($urandom), PIX_W'($urandom), sx, sy);
   endtask

   // hold off until every sample has answered, then let queued writes land
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [SIZE_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic apply_shape(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      drain_results();
      write_csr(CSR_MAP_WIDTH, w);
      write_csr(CSR_MAP_HEIGHT, h);
      write_csr($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, SIZE_W'($urandom));
      map_w = usable_dim(w, MAX_WIDTH);
      map_h = usable_dim(h, MAX_HEIGHT);
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || csr_write_enable) quiet = 0;
         else quiet++;
      end
      $display("No word moved for %0d cycles, %0d samples outstanding",
               STALL_LIMIT, pending_results);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int shape;
      int shape_start;
      int roll;
      bit halfway_done;
      reset            = 1'b1;
      start            = 1'b0;
      req_func         = FUNC_WRITE;
      req_pixel_index  = '0;
      req_pixel_value  = '0;
      req_sample_x     = '0;
      req_sample_y     = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_MAP_WIDTH;
      csr_write_data   = '0;
      idle_pct         = 0;
      write_words      = 0;
      sample_words     = 0;
      map_w            = MAX_WIDTH;
      map_h            = MAX_HEIGHT;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, on the reset map size
      put_pixel(16'd0, 16'hFFFF);
      put_pixel(16'd1, 16'h0000);
      put_pixel(16'd256, 16'h0000);
      put_pixel(16'd257, 16'hFFFF);
      sample_at(17'h00000, 17'h00000);   // full-scale result
      sample_at(17'h00080, 17'h00080);   // half fraction on both axes
      sample_at(17'h000FF, 17'h000FF);   // largest fraction
      sample_at(17'h10000, 17'h1FFFF);   // negative coords clamp to zero
      sample_at(17'h0FFFF, 17'h0FFFF);   // past the far corner
      sample_at(17'h0FFFF, 17'h00000);   // right edge, neighbour clamps
      sample_at(17'h00000, 17'h0FFFF);   // bottom edge
      put_pixel(16'hFFFF, 16'h8000);     // overwrite an existing pixel
      sample_at(17'h0FF80, 17'h0FF80);
      put_pixel(16'hAAAA, 16'h5555);

      for (shape = 0; shape < NUM_SHAPES; shape++) begin
         apply_shape(shape_w[shape], shape_h[shape]);
         idle_pct     = (shape < 4) ? 14 : ((shape < 7) ? 63 : 0);
         shape_start  = write_words + sample_words;
         halfway_done = 1'b0;
         while (write_words + sample_words - shape_start < WORDS_PER_SHAPE) begin
            roll = $urandom_range(99);
            if (roll < 65) sample_at(pick_coord(map_w), pick_coord(map_h));
            else if (roll < 90) put_pixel(ADDR_W'($urandom_range(map_w * map_h - 1)),
                                          pick_height());
            else put_pixel(ADDR_W'($urandom), pick_height());
            if (!halfway_done &&
                write_words + sample_words - shape_start >= WORDS_PER_SHAPE / 2) begin
               halfway_done = 1'b1;
               drain_results();
            end
         end
      end

      drain_results();
      $display("Covered %0d pixel writes and %0d samples on %0d map shapes", write_words,
               sample_words, NUM_SHAPES + 1);
      $display("(size extremes, zero and oversize registers, signed clamps); %0d checked",
               results_checked);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

### filelist.f
rtl/bhs_pkg.sv
rtl/bhs_front.sv
rtl/bhs_queue.sv
rtl/bhs_back.sv
rtl/bilinear_heightmap_sample.sv
tb/bilinear_heightmap_sample_checker.sv
tb/bilinear_heightmap_sample_tb.sv
